// File: rtl/triangle_to_wireframe_indices_assert.svh
// assertion macros used by the line emitter of the wireframe index assembler
`ifndef TRIANGLE_TO_WIREFRAME_INDICES_ASSERT_SVH
`define TRIANGLE_TO_WIREFRAME_INDICES_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tw_pkg.sv
// types and constants of the wireframe index assembler
`timescale 1ns / 1ps
`default_nettype none
package tw_pkg;

  localparam int WORD_BITS = 32;

  localparam logic [1:0] MODE_LIST  = 2'd0;
  localparam logic [1:0] MODE_FAN   = 2'd1;
  localparam logic [1:0] MODE_STRIP = 2'd2;

  localparam logic REG_PRIM_MODE = 1'b0;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_CNT_BITS = 3;

  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_AB_B  = 3'd1;
  localparam logic [2:0] STEP_BC_B  = 3'd2;
  localparam logic [2:0] STEP_BC_C  = 3'd3;
  localparam logic [2:0] STEP_CA_C  = 3'd4;
  localparam logic [2:0] STEP_LAST  = 3'd5;

  localparam logic [WORD_BITS-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    PHASE_EMPTY,
    PHASE_ONE,
    PHASE_READY
  } phase_t;

  typedef struct packed {
    logic has_tri;
    logic clear;
  } tw_ctl_t;

endpackage
`default_nettype wire

// File: rtl/triangle_to_wireframe_indices.sv
// top level of the triangle to wireframe index assembler
//
//  channel | direction | handshake              | word
//  in      | input     | in_valid / in_stall    | vertex_index, end_of_draw
//  out     | output    | out_valid / out_stall  | line_index, output_position, last_of_run
//  cfg     | input     | psel/penable/pready    | prim_mode at byte address 0
//
// a vertex that completes no triangle and ends no draw stays in the front end, off the queue
// a completed triangle holds the line emitter for six indices, one index per cycle unless out_stall holds
// a four-entry queue lets the front end run ahead while the emitter is busy
// synchronous active-low reset clears the draw state, count and mode to list
// out_stall holds the output register; in_stall rises only when the queue is full
`timescale 1ns / 1ps
`default_nettype none
module triangle_to_wireframe_indices #(
  parameter int INDEX_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_vertex_index,
  input  wire logic        in_end_of_draw,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_line_index,
  output logic [31:0]      out_output_position,
  output logic             out_last_of_run,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int QUEUE_BITS = 2 + 3 * INDEX_BITS;

  logic [1:0]             mode_r;
  logic                   q_push, q_pop, q_full, q_valid;
  tw_pkg::tw_ctl_t        push_ctl, pop_ctl;
  logic [INDEX_BITS-1:0]  push_a, push_b, push_c;
  logic [INDEX_BITS-1:0]  pop_a, pop_b, pop_c;
  logic [QUEUE_BITS-1:0]  push_data, pop_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tw_pkg::REG_PRIM_MODE) ? 32'(mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tw_pkg::MODE_LIST;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == tw_pkg::REG_PRIM_MODE) begin
      mode_r <= pwdata[1:0];
    end
  end

  tw_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vertex_index (in_vertex_index),
    .in_end_of_draw  (in_end_of_draw),
    .prim_mode       (mode_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_ctl           (push_ctl),
    .q_a             (push_a),
    .q_b             (push_b),
    .q_c             (push_c)
  );

  assign push_data = {push_ctl, push_a, push_b, push_c};
  assign {pop_ctl, pop_a, pop_b, pop_c} = pop_data;

  tw_fifo #(.DATA_BITS(QUEUE_BITS)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .rd_valid  (q_valid),
    .rd_data   (pop_data)
  );

  tw_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_ctl               (pop_ctl),
    .q_a                 (pop_a),
    .q_b                 (pop_b),
    .q_c                 (pop_c),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_line_index      (out_line_index),
    .out_output_position (out_output_position),
    .out_last_of_run     (out_last_of_run)
  );

endmodule
`default_nettype wire

// File: rtl/tw_fifo.sv
// short queue between the vertex front end and the line emitter
`timescale 1ns / 1ps
`default_nettype none
module tw_fifo #(
  parameter int DATA_BITS = 98
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [DATA_BITS-1:0] push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      rd_valid,
  output logic [DATA_BITS-1:0]      rd_data
);

  logic [DATA_BITS-1:0]              mem_r [tw_pkg::QUEUE_DEPTH];
  logic [tw_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_r;
  logic [tw_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_r;
  logic [tw_pkg::QUEUE_CNT_BITS-1:0] cnt_r;

  assign full     = (cnt_r == tw_pkg::QUEUE_CNT_BITS'(tw_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/tw_front.sv
// vertex front end: holds the first and two latest vertices of the draw and classifies each word
`timescale 1ns / 1ps
`default_nettype none
module tw_front #(
  parameter int INDEX_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tw_pkg::WORD_BITS-1:0] in_vertex_index,
  input  wire logic                        in_end_of_draw,
  input  wire logic [1:0]                  prim_mode,
  input  wire logic                        q_full,
  output logic                             q_push,
  output tw_pkg::tw_ctl_t                  q_ctl,
  output logic [INDEX_BITS-1:0]            q_a,
  output logic [INDEX_BITS-1:0]            q_b,
  output logic [INDEX_BITS-1:0]            q_c
);

  tw_pkg::phase_t          phase_r, phase_nxt;
  logic [INDEX_BITS-1:0]   first_r, first_nxt;
  logic [INDEX_BITS-1:0]   older_r, older_nxt;
  logic [INDEX_BITS-1:0]   newer_r, newer_nxt;
  logic [INDEX_BITS-1:0]   v;
  logic                    accept;
  logic                    has_tri;
  logic                    distinct;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign v        = in_vertex_index[INDEX_BITS-1:0];
  assign distinct = (older_r != newer_r) && (newer_r != v) && (v != older_r);

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    has_tri   = 1'b0;
    q_a       = older_r;
    q_b       = newer_r;
    q_c       = v;
    case (phase_r)
      tw_pkg::PHASE_EMPTY: begin
        first_nxt = v;
        older_nxt = v;
        phase_nxt = tw_pkg::PHASE_ONE;
      end
      tw_pkg::PHASE_ONE: begin
        newer_nxt = v;
        phase_nxt = tw_pkg::PHASE_READY;
      end
      tw_pkg::PHASE_READY: begin
        case (prim_mode)
          tw_pkg::MODE_LIST: begin
            has_tri   = 1'b1;
            phase_nxt = tw_pkg::PHASE_EMPTY;
          end
          tw_pkg::MODE_FAN: begin
            has_tri   = 1'b1;
            q_a       = first_r;
            older_nxt = newer_r;
            newer_nxt = v;
          end
          tw_pkg::MODE_STRIP: begin
            has_tri   = distinct;
            older_nxt = newer_r;
            newer_nxt = v;
          end
          default: begin
            older_nxt = newer_r;
            newer_nxt = v;
          end
        endcase
      end
      default: begin
        phase_nxt = tw_pkg::PHASE_EMPTY;
      end
    endcase
    if (in_end_of_draw) begin
      phase_nxt = tw_pkg::PHASE_EMPTY;
      first_nxt = '0;
      older_nxt = '0;
      newer_nxt = '0;
    end
  end

  assign q_push        = accept && (has_tri || in_end_of_draw);
  assign q_ctl.has_tri = has_tri;
  assign q_ctl.clear   = in_end_of_draw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tw_pkg::PHASE_EMPTY;
      first_r <= '0;
      older_r <= '0;
      newer_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tw_back.sv
// line emitter: expands each triangle into six indices with positions
`timescale 1ns / 1ps
`default_nettype none
module tw_back #(
  parameter int INDEX_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire tw_pkg::tw_ctl_t              q_ctl,
  input  wire logic [INDEX_BITS-1:0]        q_a,
  input  wire logic [INDEX_BITS-1:0]        q_b,
  input  wire logic [INDEX_BITS-1:0]        q_c,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [tw_pkg::WORD_BITS-1:0]      out_line_index,
  output logic [tw_pkg::WORD_BITS-1:0]      out_output_position,
  output logic                              out_last_of_run
);

  logic                          busy_r, busy_nxt;
  logic [2:0]                    step_r, step_nxt;
  logic [INDEX_BITS-1:0]         a_r, b_r, c_r;
  logic                          clear_r;
  logic [tw_pkg::WORD_BITS-1:0]  count_r, count_nxt;
  logic                          out_valid_r;
  logic [tw_pkg::WORD_BITS-1:0]  out_index_r;
  logic [tw_pkg::WORD_BITS-1:0]  out_pos_r;
  logic                          out_last_r;
  logic                          load;
  logic                          emit;
  logic                          finish;
  logic [INDEX_BITS-1:0]         sel;

  assign load   = !out_valid_r || !out_stall;
  assign emit   = busy_r && load;
  assign finish = emit && (step_r == tw_pkg::STEP_LAST);
  assign q_pop  = q_valid && (!busy_r || finish);

  always_comb begin
    case (step_r)
      tw_pkg::STEP_FIRST: sel = a_r;
      tw_pkg::STEP_AB_B:  sel = b_r;
      tw_pkg::STEP_BC_B:  sel = b_r;
      tw_pkg::STEP_BC_C:  sel = c_r;
      tw_pkg::STEP_CA_C:  sel = c_r;
      default:            sel = a_r;
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    if (emit) begin
      step_nxt = step_r + 1'b1;
      if (count_r != tw_pkg::POS_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (finish) begin
      busy_nxt = 1'b0;
      if (clear_r) begin
        count_nxt = '0;
      end
    end
    if (q_pop) begin
      busy_nxt = q_ctl.has_tri;
      step_nxt = tw_pkg::STEP_FIRST;
      if (!q_ctl.has_tri) begin
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_r     <= q_a;
      b_r     <= q_b;
      c_r     <= q_c;
      clear_r <= q_ctl.clear;
    end
    if (emit) begin
      out_index_r <= 32'(sel);
      out_pos_r   <= count_r;
      out_last_r  <= (step_r == tw_pkg::STEP_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= tw_pkg::STEP_FIRST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      step_r  <= step_nxt;
      count_r <= count_nxt;
      if (load) begin
        out_valid_r <= busy_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_line_index      = out_index_r;
  assign out_output_position = out_pos_r;
  assign out_last_of_run     = out_last_r;

`include "triangle_to_wireframe_indices_assert.svh"

  `TW_ASSERT_NOW(a_step_range, busy_r, step_r <= tw_pkg::STEP_LAST, "step past last")
  `TW_ASSERT_NOW(a_pop_idle, q_pop, !busy_r || finish, "queue popped mid run")
  `TW_ASSERT_NEXT(a_clear_after, finish && clear_r && !(q_valid && q_ctl.has_tri), count_r == '0, "count not cleared")
  `TW_ASSERT_NEXT(a_last_word, emit && step_r == tw_pkg::STEP_LAST, out_valid && out_last_of_run, "run end lost")

endmodule
`default_nettype wire
